// ----- rtl/core/hsb_pkg.sv -----
// Shared types, sector codes and helper functions for the HSB to RGB converter.
// Used by every module under rtl/core; depends on nothing else.
package hsb_pkg;

	// Hue sector, one sixth of a full turn each.
	typedef enum logic [2:0] {
		SECTOR_RED_YELLOW   = 3'd0,
		SECTOR_YELLOW_GREEN = 3'd1,
		SECTOR_GREEN_CYAN   = 3'd2,
		SECTOR_CYAN_BLUE    = 3'd3,
		SECTOR_BLUE_MAGENTA = 3'd4,
		SECTOR_MAGENTA_RED  = 3'd5
	} sector_t;

	localparam int unsigned LevelW = 8;
	localparam int unsigned FracW  = 16;

	// 255 scaled by the fraction one, 255 * 65536.
	localparam logic [23:0] LEVEL_FRAC_ONE = 24'hFF0000;

	// Hue split into sector and in-sector fraction.
	typedef struct packed {
		sector_t             sector;
		logic [FracW-1:0]    frac;
		logic [LevelW-1:0]   sat;
		logic [LevelW-1:0]   bright;
	} hsb_split_t;

	// Scaled levels before the final division by 255.
	typedef struct packed {
		sector_t             sector;
		logic [LevelW-1:0]   bright;
		logic [15:0]         p_num;
		logic [15:0]         q_num;
		logic [15:0]         t_num;
	} hsb_levels_t;

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [LevelW-1:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

endpackage

// ----- rtl/core/hsb_hue_split.sv -----
// First pipeline stage: multiplies the hue by six and splits it into sector and fraction.
// Depends on hsb_pkg.
module hsb_hue_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          hue_turn,
	input  logic [7:0]           sat_level,
	input  logic [7:0]           bright_level,
	output logic                 split_valid,
	input  logic                 split_ready,
	output hsb_pkg::hsb_split_t  split_data
);

	logic                valid_s1;
	hsb_pkg::hsb_split_t data_s1;
	logic [18:0]         hue6;

	assign hue6 = {1'b0, hue_turn, 2'b00} + {2'b00, hue_turn, 1'b0};

	assign in_ready    = !valid_s1 || split_ready;
	assign split_valid = valid_s1;
	assign split_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.sector <= hsb_pkg::sector_t'(hue6[18:16]);
			data_s1.frac   <= hue6[15:0];
			data_s1.sat    <= sat_level;
			data_s1.bright <= bright_level;
		end
	end

endmodule

// ----- rtl/core/hsb_level_mult.sv -----
// Second and third pipeline stages: form s*f and the p product, then scale brightness for q and t.
// Depends on hsb_pkg.
module hsb_level_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 split_valid,
	output logic                 split_ready,
	input  hsb_pkg::hsb_split_t  split_data,
	output logic                 lvl_valid,
	input  logic                 lvl_ready,
	output hsb_pkg::hsb_levels_t lvl_data
);

	logic                 valid_s2;
	logic                 valid_s3;
	logic                 adv_s2;
	logic                 adv_s3;
	hsb_pkg::sector_t     sector_s2;
	logic [7:0]           sat_s2;
	logic [7:0]           bright_s2;
	logic [23:0]          sf_s2;
	logic [15:0]          pprod_s2;
	hsb_pkg::hsb_levels_t data_s3;
	logic [23:0]          q_factor;
	logic [23:0]          t_factor;
	logic [31:0]          q_prod;
	logic [31:0]          t_prod;

	assign adv_s3      = !valid_s3 || lvl_ready;
	assign adv_s2      = !valid_s2 || adv_s3;
	assign split_ready = adv_s2;
	assign lvl_valid   = valid_s3;
	assign lvl_data    = data_s3;

	// 255*65536 - s*f and 255*65536 - s*(65536 - f) = (255 - s)*65536 + s*f.
	assign q_factor = hsb_pkg::LEVEL_FRAC_ONE - sf_s2;
	assign t_factor = {8'hFF - sat_s2, 16'h0000} + sf_s2;
	assign q_prod   = {24'd0, bright_s2} * {8'd0, q_factor};
	assign t_prod   = {24'd0, bright_s2} * {8'd0, t_factor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= split_valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && split_valid) begin
			sector_s2 <= split_data.sector;
			sat_s2    <= split_data.sat;
			bright_s2 <= split_data.bright;
			sf_s2     <= {16'd0, split_data.sat} * {8'd0, split_data.frac};
			pprod_s2  <= {8'd0, split_data.bright} * {8'd0, 8'hFF - split_data.sat};
		end
		if (adv_s3 && valid_s2) begin
			data_s3.sector <= sector_s2;
			data_s3.bright <= bright_s2;
			data_s3.p_num  <= pprod_s2;
			// Dropping the low 16 bits first leaves the floor of the quotient unchanged.
			data_s3.q_num  <= q_prod[31:16];
			data_s3.t_num  <= t_prod[31:16];
		end
	end

endmodule

// ----- rtl/core/hsb_channel_mux.sv -----
// Fourth pipeline stage: divides the levels by 255 and routes them to the channels.
// Depends on hsb_pkg; its register is the output register of the block.
module hsb_channel_mux (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 lvl_valid,
	output logic                 lvl_ready,
	input  hsb_pkg::hsb_levels_t lvl_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out
);

	logic       valid_s4;
	logic [7:0] red_s4;
	logic [7:0] green_s4;
	logic [7:0] blue_s4;
	logic [7:0] lv_v;
	logic [7:0] lv_p;
	logic [7:0] lv_q;
	logic [7:0] lv_t;
	logic [7:0] red_d;
	logic [7:0] green_d;
	logic [7:0] blue_d;

	assign lvl_ready = !valid_s4 || out_ready;
	assign out_valid = valid_s4;
	assign red_out   = red_s4;
	assign green_out = green_s4;
	assign blue_out  = blue_s4;

	assign lv_v = lvl_data.bright;
	assign lv_p = hsb_pkg::div255(lvl_data.p_num);
	assign lv_q = hsb_pkg::div255(lvl_data.q_num);
	assign lv_t = hsb_pkg::div255(lvl_data.t_num);

	always_comb begin
		unique case (lvl_data.sector)
			hsb_pkg::SECTOR_RED_YELLOW: begin
				red_d = lv_v; green_d = lv_t; blue_d = lv_p;
			end
			hsb_pkg::SECTOR_YELLOW_GREEN: begin
				red_d = lv_q; green_d = lv_v; blue_d = lv_p;
			end
			hsb_pkg::SECTOR_GREEN_CYAN: begin
				red_d = lv_p; green_d = lv_v; blue_d = lv_t;
			end
			hsb_pkg::SECTOR_CYAN_BLUE: begin
				red_d = lv_p; green_d = lv_q; blue_d = lv_v;
			end
			hsb_pkg::SECTOR_BLUE_MAGENTA: begin
				red_d = lv_t; green_d = lv_p; blue_d = lv_v;
			end
			default: begin
				red_d = lv_v; green_d = lv_p; blue_d = lv_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (lvl_ready) begin
			valid_s4 <= lvl_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_ready && lvl_valid) begin
			red_s4   <= red_d;
			green_s4 <= green_d;
			blue_s4  <= blue_d;
		end
	end

endmodule

// ----- rtl/core/hsb_to_rgb_converter_unit.sv -----
// Top level of the HSB to RGB converter: four-stage pipeline.
// Depends on hsb_pkg, hsb_hue_split, hsb_level_mult and hsb_channel_mux.
//
// Usage:
//   The input channel (in_valid, in_ready) carries one request of hue_turn,
//   sat_level and bright_level; the output channel (out_valid, out_ready)
//   returns red_out, green_out and blue_out for it. Requests leave in order.
//   A new request is accepted every cycle while the receiver keeps
//   out_ready high; the four registered stages are hue times six, the
//   s*f product, the two brightness products, and the division by 255
//   with channel routing into the output register.
//   Each stage advances when it is empty or the stage after it moves, so
//   when the receiver holds out_ready low the bubbles fill first and
//   in_ready drops only once all four stages hold a request. Nothing is
//   lost or repeated across a stall.
//   Reset (arst_n low) empties every stage; no request is pending after it.
module hsb_to_rgb_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue_turn,
	input  logic [7:0]  sat_level,
	input  logic [7:0]  bright_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);

	logic                 split_valid;
	logic                 split_ready;
	hsb_pkg::hsb_split_t  split_data;
	logic                 lvl_valid;
	logic                 lvl_ready;
	hsb_pkg::hsb_levels_t lvl_data;
	logic [2:0]           inflight_q;

	hsb_hue_split u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hue_turn     (hue_turn),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.split_valid  (split_valid),
		.split_ready  (split_ready),
		.split_data   (split_data)
	);

	hsb_level_mult u_mult (
		.clk         (clk),
		.arst_n      (arst_n),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.split_data  (split_data),
		.lvl_valid   (lvl_valid),
		.lvl_ready   (lvl_ready),
		.lvl_data    (lvl_data)
	);

	hsb_channel_mux u_mux (
		.clk       (clk),
		.arst_n    (arst_n),
		.lvl_valid (lvl_valid),
		.lvl_ready (lvl_ready),
		.lvl_data  (lvl_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	// Count of requests inside the pipeline, kept for the checks below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more requests in flight than pipeline stages");

	a_out_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result shown with no request in flight");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (split_valid && lvl_valid && out_valid && inflight_q == 3'd4))
		else $error("input blocked while a stage is empty");

	a_lvl_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_valid && !lvl_ready) |=> (lvl_valid && $stable(lvl_data)))
		else $error("stalled level stage changed");

endmodule

// ----- test/hsb_to_rgb_converter_unit_tb.sv -----
// Testbench for hsb_to_rgb_converter_unit: sends directed and random HSB requests with
// random idling on both channels and checks every RGB result against an integer predictor.
// Depends on hsb_pkg and the converter RTL.

typedef struct packed {
	logic [15:0] hue;
	logic [7:0]  sat;
	logic [7:0]  bright;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
} color_entry_t;

class rgb_scoreboard;
	color_entry_t expected_colors[$];
	int unsigned  mismatches;

	// Exact integer HSV to RGB, every level rounded down.
	static function color_entry_t hsv_to_rgb(logic [15:0] hue, logic [7:0] sat,
		logic [7:0] bright);
		color_entry_t      c;
		logic [18:0]       h6;
		hsb_pkg::sector_t  sector;
		bit [63:0]         frac, v, s, den, p, q, t;
		c.hue = hue;
		c.sat = sat;
		c.bright = bright;
		h6 = 19'(hue) * 19'd6;
		sector = hsb_pkg::sector_t'(h6[18:16]);
		frac = 64'(h6[15:0]);
		v = 64'(bright);
		s = 64'(sat);
		den = 64'(hsb_pkg::LEVEL_FRAC_ONE);
		p = v * (64'd255 - s) / 64'd255;
		q = v * (den - s * frac) / den;
		t = v * (den - s * (64'd65536 - frac)) / den;
		if (sat == 8'd0) begin
			c.red = bright;
			c.green = bright;
			c.blue = bright;
		end else begin
			unique case (sector)
				hsb_pkg::SECTOR_RED_YELLOW: begin
					c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0];
				end
				hsb_pkg::SECTOR_YELLOW_GREEN: begin
					c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0];
				end
				hsb_pkg::SECTOR_GREEN_CYAN: begin
					c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0];
				end
				hsb_pkg::SECTOR_CYAN_BLUE: begin
					c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0];
				end
				hsb_pkg::SECTOR_BLUE_MAGENTA: begin
					c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0];
				end
				// The magenta to red sector is the only one left.
				default: begin
					c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0];
				end
			endcase
		end
		return c;
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("mismatch: %s", what);
	endtask

	function void note_request(logic [15:0] hue, logic [7:0] sat, logic [7:0] bright);
		expected_colors.push_back(hsv_to_rgb(hue, sat, bright));
	endfunction

	function int unsigned pending();
		return expected_colors.size();
	endfunction

	task check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		color_entry_t want;
		if (expected_colors.size() == 0) begin
			report_mismatch($sformatf("result r=%0d g=%0d b=%0d with no request pending",
				red, green, blue));
		end else begin
			want = expected_colors.pop_front();
			if (red !== want.red)
				report_mismatch($sformatf("red %0d, expected %0d (hue %0d sat %0d bright %0d)",
					red, want.red, want.hue, want.sat, want.bright));
			if (green !== want.green)
				report_mismatch($sformatf("green %0d, expected %0d (hue %0d sat %0d bright %0d)",
					green, want.green, want.hue, want.sat, want.bright));
			if (blue !== want.blue)
				report_mismatch($sformatf("blue %0d, expected %0d (hue %0d sat %0d bright %0d)",
					blue, want.blue, want.hue, want.sat, want.bright));
		end
	endtask
endclass

module hsb_to_rgb_converter_unit_tb;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] hue_turn;
	logic [7:0]  sat_level;
	logic [7:0]  bright_level;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;

	int unsigned tx_max_gap;
	int unsigned rx_max_gap;
	bit          rx_hold;
	int unsigned tx_gap_by_phase[6] = '{0, 0, 17, 0, 17, 5};
	int unsigned rx_gap_by_phase[6] = '{0, 0, 0, 17, 17, 5};

	rgb_scoreboard color_checker = new;

	hsb_to_rgb_converter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hue_turn     (hue_turn),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out)
	);

	always #5 clk = ~clk;

	task send_request(input logic [15:0] hue, input logic [7:0] sat, input logic [7:0] bright);
		int unsigned gap;
		gap = $urandom_range(tx_max_gap, 0);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		hue_turn = hue;
		sat_level = sat;
		bright_level = bright;
		do @(posedge clk); while (!in_ready);
		color_checker.note_request(hue, sat, bright);
	endtask

	task pause_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (color_checker.pending() != 0)
			@(posedge clk);
	endtask

	task hold_off_receiver(input int unsigned cycles);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	// Hues lean toward the sector boundaries, where the fraction wraps.
	function automatic logic [15:0] pick_hue();
		int unsigned sel;
		int unsigned k;
		sel = $urandom_range(15, 0);
		k = $urandom_range(5, 1);
		if (sel == 0)
			return 16'h0000;
		else if (sel == 1)
			return 16'hFFFF;
		else if (sel < 5)
			return 16'((k * 65536 + 5) / 6 + $urandom_range(4, 0) - 2);
		else
			return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_level();
		int unsigned sel;
		sel = $urandom_range(7, 0);
		if (sel == 0)
			return 8'd0;
		else if (sel == 1)
			return 8'd255;
		else
			return 8'($urandom);
	endfunction

	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(rx_max_gap, 0);
			repeat (gap) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			@(negedge clk);
			while (rx_hold) begin
				out_ready = 1'b0;
				@(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			color_checker.check_result(red_out, green_out, blue_out);
		end
	end

	initial begin
		int unsigned k;
		int unsigned boundary;
		int unsigned phase;
		in_valid = 1'b0;
		hue_turn = 16'd0;
		sat_level = 8'd0;
		bright_level = 8'd0;
		arst_n = 1'b0;
		rx_hold = 1'b0;
		tx_max_gap = 0;
		rx_max_gap = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(16'h0000, 8'd255, 8'd255);
		send_request(16'hFFFF, 8'd255, 8'd255);
		// Just below and at each sector boundary.
		for (k = 1; k <= 5; k++) begin
			boundary = (k * 65536 + 5) / 6;
			send_request(16'(boundary - 1), 8'd255, 8'd255);
			send_request(16'(boundary), 8'd255, 8'd255);
		end
		// Zero saturation must come out grey.
		send_request(16'd20000, 8'd0, 8'd200);
		send_request(16'hFFFF, 8'd0, 8'd255);
		send_request(16'd40000, 8'd255, 8'd0);
		send_request(16'd5000, 8'd1, 8'd255);
		send_request(16'd60000, 8'd255, 8'd1);
		for (k = 0; k < 6; k++)
			send_request(16'((2 * k + 1) * 65536 / 12), 8'd170, 8'd213);
		send_request(16'hAAAA, 8'h55, 8'hAA);
		send_request(16'h5555, 8'hAA, 8'h55);
		pause_until_drained();

		for (phase = 0; phase < 6; phase++) begin
			tx_max_gap = tx_gap_by_phase[phase];
			rx_max_gap = rx_gap_by_phase[phase];
			// Back-to-back requests against a stalled receiver fill the pipeline.
			if (phase == 1) begin
				fork
					hold_off_receiver(64);
				join_none
			end
			repeat (292) send_request(pick_hue(), pick_level(), pick_level());
			pause_until_drained();
		end

		repeat (12) @(posedge clk);
		if (color_checker.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end
endmodule
